### sv/wnpd_pkg.sv
// package for the windowed nearest point delta block
// sizes, action and register codes, scan control struct and the cosine table builder
// no dependencies
`default_nettype none

package wnpd_pkg;

  // sizing
  localparam int MAX_POINTS  = 4096;
  localparam int WINDOW      = 60;
  localparam int COS_ENTRIES = 901;

  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int COS_IDX_W = $clog2(COS_ENTRIES);

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int PIDX_W = 12;
  localparam int PCNT_W = 13;
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int TIME_W = 32;
  localparam int PT_W   = LAT_W + LON_W + TIME_W;
  localparam int COS_W  = 15;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  // configuration register indexes
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_REF_VALID   = 1'b1;

  // rom index: (|lat| + half step) / 1e6 by reciprocal, exact for values below 2^31
  localparam logic [30:0] HALF_STEP = 31'd500000;
  localparam logic [31:0] RECIP_1E6 = 32'd2251799814;
  localparam int          DIV_SHIFT = 51;
  localparam int          QUO_W     = 12;

  // saturation point of the coordinate differences
  localparam logic [32:0] DIFF_CAP = 33'd1073741824;

  // one scan slot travelling with a store read
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef logic [COS_ENTRIES-1:0][15:0] cos_rom_t;

  // cosine table in q1.15, ten term series on a q30 angle, evaluated at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t           rom;
    logic        [63:0] a;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] q;
    logic signed [63:0] sum;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      a    = (k <= 900) ? 64'(k) : 64'd900;
      x    = (a * 64'd3373259426 + 64'd900) / 64'd1800;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = $signed(term);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      q = ($unsigned(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[k] = q[15:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

### sv/wnpd_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module wnpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/wnpd_cos_lookup.sv
// latitude to cosine factor: reciprocal divide stage, then registered table read
// depends on wnpd_pkg
`default_nettype none

module wnpd_cos_lookup
  import wnpd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [LAT_W-1:0] lat_i,
  output logic             [COS_W-1:0] cos_o
);

  localparam cos_rom_t CosRom = build_cos_rom();

  logic [LAT_W-1:0]     abs_lat;
  logic [LAT_W-1:0]     biased;
  logic [63:0]          prod;
  logic [QUO_W-1:0]     quo_d;
  logic [QUO_W-1:0]     quo_q;
  logic [COS_IDX_W-1:0] rom_idx;
  logic [COS_W-1:0]     cos_d;
  logic [COS_W-1:0]     cos_q;

  // |lat| rounded to tenths of a degree by reciprocal multiply
  always_comb begin
    abs_lat = lat_i[LAT_W-1] ? LAT_W'(-lat_i) : LAT_W'(lat_i);
    biased  = abs_lat + HALF_STEP;
    prod    = 64'(biased) * 64'(RECIP_1E6);
    quo_d   = prod[DIV_SHIFT+QUO_W-1:DIV_SHIFT];
  end

  // cap at the last entry and look up
  always_comb begin
    if (int'(quo_q) > COS_ENTRIES - 1) begin
      rom_idx = COS_IDX_W'(COS_ENTRIES - 1);
    end else begin
      rom_idx = COS_IDX_W'(quo_q);
    end
    cos_d = CosRom[rom_idx][COS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    cos_q <= cos_d;
  end

  assign cos_o = cos_q;

endmodule

`default_nettype wire

### sv/wnpd_dist_pipe.sv
// three stage distance pipeline with first minimum tracking
// depends on wnpd_pkg
`default_nettype none

module wnpd_dist_pipe
  import wnpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scan_ctl_t                ctl_i,
  input  wire logic signed [LAT_W-1:0]  pt_lat_i,
  input  wire logic signed [LON_W-1:0]  pt_lon_i,
  input  wire logic        [TIME_W-1:0] pt_time_i,
  input  wire logic signed [LAT_W-1:0]  q_lat_i,
  input  wire logic signed [LON_W-1:0]  q_lon_i,
  input  wire logic        [COS_W-1:0]  cos_i,
  output logic                          done_o,
  output logic             [IDX_W-1:0]  near_idx_o,
  output logic             [TIME_W-1:0] best_time_o
);

  // stage 1: differences, lat saturation, lon times cosine
  logic signed [32:0] dlat_diff;
  logic signed [32:0] dlon_diff;
  logic        [32:0] dlat_mag;
  logic        [32:0] dlon_mag;
  logic        [30:0] dlat_cap;
  logic        [46:0] dlon_prod;

  scan_ctl_t          s1_ctl_q;
  logic [TIME_W-1:0]  s1_time_q;
  logic [30:0]        s1_dlat_q;
  logic [46:0]        s1_prod_q;

  always_comb begin
    dlat_diff = 33'(pt_lat_i) - 33'(q_lat_i);
    dlon_diff = 33'(pt_lon_i) - 33'(q_lon_i);
    dlat_mag  = dlat_diff[32] ? 33'(-dlat_diff) : 33'(dlat_diff);
    dlon_mag  = dlon_diff[32] ? 33'(-dlon_diff) : 33'(dlon_diff);
    dlat_cap  = (dlat_mag > DIFF_CAP) ? DIFF_CAP[30:0] : dlat_mag[30:0];
    dlon_prod = 47'(dlon_mag[31:0]) * 47'(cos_i);
  end

  // stage 2: round and saturate lon, square both
  logic [47:0] dlon_rnd;
  logic [32:0] dlon_sh;
  logic [30:0] dlon_cap;

  scan_ctl_t         s2_ctl_q;
  logic [TIME_W-1:0] s2_time_q;
  logic [60:0]       s2_sq_lat_q;
  logic [60:0]       s2_sq_lon_q;
  logic [61:0]       sq_lat;
  logic [61:0]       sq_lon;

  always_comb begin
    dlon_rnd = 48'(s1_prod_q) + 48'd16384;
    dlon_sh  = dlon_rnd[47:15];
    dlon_cap = (dlon_sh > DIFF_CAP) ? DIFF_CAP[30:0] : dlon_sh[30:0];
    sq_lat   = 62'(s1_dlat_q) * 62'(s1_dlat_q);
    sq_lon   = 62'(dlon_cap) * 62'(dlon_cap);
  end

  // stage 3: sum and compare against the running best
  logic [61:0]       sum_sq;
  logic              take;
  logic [61:0]       best_d_q;
  logic [IDX_W-1:0]  near_idx_q;
  logic [TIME_W-1:0] best_time_q;
  logic              done_q;

  always_comb begin
    sum_sq = 62'(s2_sq_lat_q) + 62'(s2_sq_lon_q);
    take   = s2_ctl_q.valid && (s2_ctl_q.first || (sum_sq < best_d_q));
  end

  // pipeline valid and done flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
      done_q   <= s2_ctl_q.valid && s2_ctl_q.last;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_time_q   <= pt_time_i;
    s1_dlat_q   <= dlat_cap;
    s1_prod_q   <= dlon_prod;
    s2_time_q   <= s1_time_q;
    s2_sq_lat_q <= sq_lat[60:0];
    s2_sq_lon_q <= sq_lon[60:0];
    if (take) begin
      best_d_q    <= sum_sq;
      near_idx_q  <= s2_ctl_q.idx;
      best_time_q <= s2_time_q;
    end
  end

  assign done_o      = done_q;
  assign near_idx_o  = near_idx_q;
  assign best_time_o = best_time_q;

endmodule

`default_nettype wire

### sv/windowed_nearest_point_delta_top.sv
// top level of the windowed nearest point delta block
// depends on wnpd_pkg, wnpd_ram, wnpd_cos_lookup and wnpd_dist_pipe
`default_nettype none

// Usage
//   input channel: a transaction is taken when start is high and busy is low.
//   action load writes one reference point into the point store in the accept cycle,
//   action restart clears the cursor and the held delta; neither gives a result and
//   both leave busy low, so a new transaction can follow in the next cycle.
//   action update with no valid reference (ref_valid low or point count zero) gives
//   the held delta and cursor with updated_o low in the cycle after accept.
//   otherwise the update scans n = min(start + 60, count - 1) - start + 1 points
//   (at most 61) from start = min(cursor, count - 1), one point per cycle from
//   the store memory; the read port sets the rate. busy is high through the cosine
//   step, scan and distance pipeline, dropping in the cycle result_valid_o pulses.
//   results hold for one cycle only; the receiver cannot stall.
//   configuration: cfg_we_i writes register cfg_idx_i (0 point count, 1 ref valid)
//   at once; write only while busy is low.
//   reset clears cursor, held delta and configuration; the point store is not
//   cleared and must be loaded before use.

module windowed_nearest_point_delta_top
  import wnpd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic        [PCNT_W-1:0] cfg_data_i,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [ACT_W-1:0]  action_i,
  input  wire logic        [PIDX_W-1:0] point_index_i,
  input  wire logic signed [LAT_W-1:0]  lat_i,
  input  wire logic signed [LON_W-1:0]  lon_i,
  input  wire logic        [TIME_W-1:0] time_ms_i,
  output logic                          result_valid_o,
  output logic signed      [31:0]       delta_ms_o,
  output logic             [PIDX_W-1:0] ref_index_o,
  output logic                          updated_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COS,
    ST_SCAN,
    ST_WAIT
  } state_e;

  state_e state_q;

  logic [PCNT_W-1:0]       pt_count_q;
  logic                    ref_valid_q;
  logic [IDX_W-1:0]        cursor_q;
  logic [31:0]             held_q;
  logic [IDX_W-1:0]        start_q;
  logic [IDX_W-1:0]        end_q;
  logic [IDX_W-1:0]        rd_addr_q;
  scan_ctl_t               ctl_q;
  logic                    res_valid_q;
  logic [31:0]             res_delta_q;
  logic [IDX_W-1:0]        res_index_q;
  logic                    res_updated_q;
  logic signed [LAT_W-1:0] lat_q;
  logic signed [LON_W-1:0] lon_q;
  logic [TIME_W-1:0]       time_q;

  logic accept;
  logic ram_we;
  logic ram_re;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign ram_we = accept && (action_i == ACT_LOAD) && (32'(point_index_i) < 32'(MAX_POINTS));
  assign ram_re = (state_q == ST_SCAN);

  // window bounds from cursor and point count
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] last_pt;
  logic [CNT_W-1:0] start_pt;
  logic [CNT_W:0]   end_sum;
  logic [CNT_W-1:0] end_pt;
  logic             search_ok;

  always_comb begin
    if (32'(pt_count_q) > 32'(MAX_POINTS)) begin
      cnt_eff = CNT_W'(MAX_POINTS);
    end else begin
      cnt_eff = CNT_W'(pt_count_q);
    end
    last_pt   = cnt_eff - CNT_W'(1);
    start_pt  = (CNT_W'(cursor_q) < cnt_eff) ? CNT_W'(cursor_q) : last_pt;
    end_sum   = (CNT_W + 1)'(start_pt) + (CNT_W + 1)'(WINDOW);
    end_pt    = (end_sum > (CNT_W + 1)'(last_pt)) ? last_pt : CNT_W'(end_sum);
    search_ok = ref_valid_q && (cnt_eff != '0);
  end

  // point store: lat, lon, lap time per entry
  logic [PT_W-1:0] ram_rdata;

  wnpd_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IDX_W'(point_index_i)),
    .wdata_i({lat_i, lon_i, time_ms_i}),
    .re_i   (ram_re),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  // cosine factor of the query latitude, registered after the divide stage
  logic [COS_W-1:0] cos_val;

  wnpd_cos_lookup u_cos (
    .clk_i(clk_i),
    .lat_i(lat_q),
    .cos_o(cos_val)
  );

  // distance and minimum
  logic              dist_done;
  logic [IDX_W-1:0]  near_idx;
  logic [TIME_W-1:0] best_time;

  wnpd_dist_pipe u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_q),
    .pt_lat_i   (ram_rdata[PT_W-1 -: LAT_W]),
    .pt_lon_i   (ram_rdata[TIME_W +: LON_W]),
    .pt_time_i  (ram_rdata[TIME_W-1:0]),
    .q_lat_i    (lat_q),
    .q_lon_i    (lon_q),
    .cos_i      (cos_val),
    .done_o     (dist_done),
    .near_idx_o (near_idx),
    .best_time_o(best_time)
  );

  // query payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q  <= lat_i;
      lon_q  <= lon_i;
      time_q <= time_ms_i;
    end
  end

  // sequencer, configuration and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pt_count_q    <= '0;
      ref_valid_q   <= 1'b0;
      cursor_q      <= '0;
      held_q        <= '0;
      start_q       <= '0;
      end_q         <= '0;
      rd_addr_q     <= '0;
      ctl_q         <= '0;
      res_valid_q   <= 1'b0;
      res_delta_q   <= '0;
      res_index_q   <= '0;
      res_updated_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      ctl_q       <= '0;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POINT_COUNT: pt_count_q  <= cfg_data_i;
          CFG_REF_VALID:   ref_valid_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (action_i)
              ACT_RESTART: begin
                cursor_q <= '0;
                held_q   <= '0;
              end
              ACT_UPDATE: begin
                if (search_ok) begin
                  start_q <= IDX_W'(start_pt);
                  end_q   <= IDX_W'(end_pt);
                  state_q <= ST_COS;
                end else begin
                  res_valid_q   <= 1'b1;
                  res_delta_q   <= held_q;
                  res_index_q   <= cursor_q;
                  res_updated_q <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_COS: begin
          rd_addr_q <= start_q;
          state_q   <= ST_SCAN;
        end
        ST_SCAN: begin
          ctl_q.valid <= 1'b1;
          ctl_q.first <= (rd_addr_q == start_q);
          ctl_q.last  <= (rd_addr_q == end_q);
          ctl_q.idx   <= rd_addr_q;
          if (rd_addr_q == end_q) begin
            state_q <= ST_WAIT;
          end else begin
            rd_addr_q <= rd_addr_q + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (dist_done) begin
            cursor_q      <= near_idx;
            held_q        <= time_q - best_time;
            res_valid_q   <= 1'b1;
            res_delta_q   <= time_q - best_time;
            res_index_q   <= near_idx;
            res_updated_q <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign delta_ms_o     = $signed(res_delta_q);
  assign ref_index_o    = PIDX_W'(res_index_q);
  assign updated_o      = res_updated_q;

endmodule

`default_nettype wire

### sv/wnpd_checker.sv
// port level checks on transaction timing of the top level, with its bind
// depends on wnpd_pkg and windowed_nearest_point_delta_top
`default_nettype none

module wnpd_checker
  import wnpd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [ACT_W-1:0] action_i,
  input wire logic             result_valid_o,
  input wire logic             updated_o
);

  logic acc_update;
  logic acc_quiet;

  assign acc_update = start && !busy && (action_i == ACT_UPDATE);
  assign acc_quiet  = start && !busy && ((action_i == ACT_LOAD) || (action_i == ACT_RESTART));

  // an update answers at once or starts a search
  a_update_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_update |=> (result_valid_o || busy))
    else $error("update transaction neither answered nor searching");

  // loads and restarts give no result
  a_quiet_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_quiet |=> !result_valid_o)
    else $error("result after load or restart transaction");

  // a no-op result follows its update directly
  a_noop_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !updated_o) |-> $past(acc_update))
    else $error("no-op result without preceding update");

  // a searched result ends a busy period
  a_search_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && updated_o) |-> ($past(busy) && !busy))
    else $error("search result outside the end of a busy period");

endmodule

bind windowed_nearest_point_delta_top wnpd_checker u_wnpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .action_i      (action_i),
  .result_valid_o(result_valid_o),
  .updated_o     (updated_o)
);

`default_nettype wire

### dv/tb.sv
// testbench for windowed_nearest_point_delta_top: lap point loads, restarts and position updates
// an in-bench lap predictor checks every update result; depends on wnpd_pkg and the rtl only
module tb;
  import wnpd_pkg::*;

  // action code with no meaning to the block
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int ITEM_GOAL     = 450;
  localparam int SETTLE_CYCLES = 70;
  localparam int DRAIN_CYCLES  = 80;
  localparam int STALL_LIMIT   = 4000;

  localparam int LAT_TOP    = 1073741823;
  localparam int LAT_BOTTOM = -1073741824;
  localparam int LON_TOP    = 2147483647;
  localparam int LON_BOTTOM = -2147483647 - 1;

  typedef enum logic [1:0] {OP_ITEM, OP_WRITE, OP_DRAIN} op_kind_e;

  // one queued stimulus step: an input transaction, a register write or a drain pause
  typedef struct packed {
    op_kind_e          kind;
    logic [ACT_W-1:0]  action;
    logic [PIDX_W-1:0] pidx;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic [TIME_W-1:0] tms;
    logic              reg_sel;
    logic [PCNT_W-1:0] reg_val;
  } stim_op_t;

  typedef struct packed {
    logic [31:0]       delta;
    logic [PIDX_W-1:0] idx;
    logic              upd;
  } lap_result_t;

  // dut signals
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic                     cfg_idx_i     = 1'b0;
  logic        [PCNT_W-1:0] cfg_data_i    = '0;
  logic                     start         = 1'b0;
  logic                     busy;
  logic        [ACT_W-1:0]  action_i      = '0;
  logic        [PIDX_W-1:0] point_index_i = '0;
  logic        [LAT_W-1:0]  lat_i         = '0;
  logic        [LON_W-1:0]  lon_i         = '0;
  logic        [TIME_W-1:0] time_ms_i     = '0;
  logic                     result_valid_o;
  logic signed [31:0]       delta_ms_o;
  logic        [PIDX_W-1:0] ref_index_o;
  logic                     updated_o;

  // predictor state
  longint            lap_lat  [MAX_POINTS];
  longint            lap_lon  [MAX_POINTS];
  logic [31:0]       lap_time [MAX_POINTS];
  logic [15:0]       cos_tab  [COS_ENTRIES];
  logic [PIDX_W-1:0] lap_cursor    = '0;
  logic [31:0]       lap_held      = '0;
  logic [PCNT_W-1:0] lap_count_reg = '0;
  logic              lap_ref_ok    = 1'b0;

  // stimulus and checking state
  stim_op_t    pending_ops[$];
  lap_result_t delta_expect_q[$];
  stim_op_t    held_op;
  int unsigned mismatch_cnt  = 0;
  int unsigned taken_items   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_cycles  = 0;

  // generator bookkeeping: which store entries are written and how far the cursor can be
  bit          gen_written [MAX_POINTS];
  int unsigned gen_prefix = 0;
  int unsigned gen_span   = 0;
  int unsigned gen_bound  = 0;
  int unsigned gen_pos    = 0;
  int unsigned gen_items  = 0;
  bit          gen_ref_ok = 1'b0;
  int          geo_lat0, geo_lon0, geo_dlat, geo_dlon;

  windowed_nearest_point_delta_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .point_index_i  (point_index_i),
    .lat_i          (lat_i),
    .lon_i          (lon_i),
    .time_ms_i      (time_ms_i),
    .result_valid_o (result_valid_o),
    .delta_ms_o     (delta_ms_o),
    .ref_index_o    (ref_index_o),
    .updated_o      (updated_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // cosine of k tenths of a degree in q1.15 from a ten term series on a q30 angle
  function automatic logic [15:0] cos_q15(input int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] q;
    longint      acc;
    int unsigned n;
    ang = k;
    if (ang > 64'd900) ang = 64'd900;
    ang    = (ang * 64'd3373259426 + 64'd900) / 64'd1800;
    ang_sq = (ang * ang + 64'd536870912) >> 30;
    term   = 64'd1 << 30;
    acc    = 64'sd1073741824;
    for (n = 1; n <= 10; n++) begin
      term = (term * ang_sq) >> 30;
      term = term / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    q = acc;
    q = (q + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  // squared distance from a position to stored point k, with cosine-scaled longitude
  function automatic logic [63:0] gap_sq(input int unsigned k, input longint plat,
                                         input longint plon, input logic [15:0] c);
    longint      dy;
    longint      dx;
    logic [63:0] uy;
    logic [63:0] ux;
    dy = lap_lat[k] - plat;
    dx = lap_lon[k] - plon;
    uy = (dy < 0) ? -dy : dy;
    ux = (dx < 0) ? -dx : dx;
    ux = (ux * c + 64'd16384) >> 15;
    if (uy > 64'd1073741824) uy = 64'd1073741824;
    if (ux > 64'd1073741824) ux = 64'd1073741824;
    return uy * uy + ux * ux;
  endfunction

  // advance the lap predictor by one accepted transaction
  task automatic lap_predict(input stim_op_t op);
    int unsigned span, ci, first, last, best, k;
    longint      plat, plon, alat;
    logic [63:0] d, bestd;
    logic [15:0] c;
    lap_result_t res;
    plat = $signed(op.lat);
    plon = $signed(op.lon);
    case (op.action)
      ACT_LOAD: begin
        lap_lat[op.pidx]  = plat;
        lap_lon[op.pidx]  = plon;
        lap_time[op.pidx] = op.tms;
      end
      ACT_RESTART: begin
        lap_cursor = '0;
        lap_held   = '0;
      end
      ACT_UPDATE: begin
        span = (lap_count_reg > MAX_POINTS) ? MAX_POINTS : lap_count_reg;
        res.upd = 1'b0;
        if (lap_ref_ok && span > 0) begin
          alat = (plat < 0) ? -plat : plat;
          ci = (alat + 500000) / 1000000;
          if (ci > COS_ENTRIES - 1) ci = COS_ENTRIES - 1;
          c = cos_tab[ci];
          // search window starts at the cursor, or the last point if the cursor is past it
          first = (lap_cursor < span) ? lap_cursor : span - 1;
          last  = (first + WINDOW < span - 1) ? first + WINDOW : span - 1;
          best  = first;
          bestd = gap_sq(first, plat, plon, c);
          for (k = first + 1; k <= last; k++) begin
            d = gap_sq(k, plat, plon, c);
            if (d < bestd) begin
              bestd = d;
              best  = k;
            end
          end
          lap_cursor = best[PIDX_W-1:0];
          lap_held   = op.tms - lap_time[best];
          res.upd    = 1'b1;
        end
        res.delta = lap_held;
        res.idx   = lap_cursor;
        delta_expect_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic int jit(input int unsigned m);
    return int'($urandom_range(0, 2 * m)) - int'(m);
  endfunction

  // queue one input transaction and keep the generator bookkeeping current
  task automatic add_item(input logic [ACT_W-1:0] act, input int unsigned idx, input int lat,
                          input int lon, input logic [TIME_W-1:0] tms);
    stim_op_t op;
    op        = '0;
    op.kind   = OP_ITEM;
    op.action = act;
    op.pidx   = idx[PIDX_W-1:0];
    op.lat    = lat[LAT_W-1:0];
    op.lon    = lon;
    op.tms    = tms;
    pending_ops.push_back(op);
    if (act != ACT_UNUSED) gen_items++;
    if (act == ACT_LOAD) begin
      gen_written[idx[PIDX_W-1:0]] = 1'b1;
      while (gen_prefix < MAX_POINTS && gen_written[gen_prefix]) gen_prefix++;
    end else if (act == ACT_RESTART) begin
      gen_bound = 0;
      gen_pos   = 0;
    end
  endtask

  task automatic add_cfg(input logic sel, input logic [PCNT_W-1:0] val);
    stim_op_t op;
    op         = '0;
    op.kind    = OP_WRITE;
    op.reg_sel = sel;
    op.reg_val = val;
    pending_ops.push_back(op);
    if (sel == CFG_POINT_COUNT) gen_span = (val > MAX_POINTS) ? MAX_POINTS : val;
    else gen_ref_ok = val[0];
  endtask

  // lap point k on the track, slightly scattered
  task automatic lap_point(input int unsigned k);
    add_item(ACT_LOAD, k, geo_lat0 + int'(k) * geo_dlat + jit(300),
             geo_lon0 + int'(k) * geo_dlon + jit(300), k * 120 + $urandom_range(0, 40));
  endtask

  // position update; first loads every point the search window could reach
  task automatic add_update(input int lat, input int lon, input logic [TIME_W-1:0] tms);
    int unsigned hi;
    if (gen_ref_ok && gen_span > 0) begin
      hi = (gen_bound + WINDOW < gen_span - 1) ? gen_bound + WINDOW : gen_span - 1;
      while (gen_prefix <= hi) lap_point(gen_prefix);
      gen_bound = hi;
    end
    add_item(ACT_UPDATE, $urandom_range(0, MAX_POINTS - 1), lat, lon, tms);
  endtask

  // driver: feeds queued transactions and register writes, idles at random
  always @(posedge clk_i) begin : drive_ops
    logic     took;
    logic     hold;
    logic     arm;
    stim_op_t op;
    if (!rst_ni) begin
      start        <= 1'b0;
      cfg_we_i     <= 1'b0;
      quiet_cycles = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        lap_predict(held_op);
        taken_items++;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POINT_COUNT) lap_count_reg = cfg_data_i;
        else lap_ref_ok = cfg_data_i[0];
      end
      if (start || busy || cfg_we_i || delta_expect_q.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      hold = start && !took;
      arm  = 1'b0;
      if (!hold && pending_ops.size() != 0) begin
        op = pending_ops[0];
        case (op.kind)
          OP_ITEM: begin
            // a stretch with no idling in the middle of the run
            if ((taken_items >= 150 && taken_items < 260) || $urandom_range(0, 99) >= 36) begin
              void'(pending_ops.pop_front());
              held_op       = op;
              hold          = 1'b1;
              action_i      <= op.action;
              point_index_i <= op.pidx;
              lat_i         <= op.lat;
              lon_i         <= op.lon;
              time_ms_i     <= op.tms;
            end
          end
          OP_WRITE: begin
            // registers change only once the block has been quiet for a while
            if (quiet_cycles >= SETTLE_CYCLES) begin
              void'(pending_ops.pop_front());
              arm          = 1'b1;
              cfg_idx_i    <= op.reg_sel;
              cfg_data_i   <= op.reg_val;
              quiet_cycles = 0;
            end
          end
          OP_DRAIN: begin
            if (delta_expect_q.size() == 0) void'(pending_ops.pop_front());
          end
          default: ;
        endcase
      end
      start    <= hold;
      cfg_we_i <= arm;
    end
  end

  // monitor: each result strobe is checked against the oldest expected delta
  always @(posedge clk_i) begin : check_results
    lap_result_t want;
    if (rst_ni && result_valid_o) begin
      if (delta_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result delta %0d idx %0d updated %0b",
                                  delta_ms_o, ref_index_o, updated_o));
      end else begin
        want = delta_expect_q.pop_front();
        if (delta_ms_o !== want.delta || ref_index_o !== want.idx || updated_o !== want.upd) begin
          report_mismatch($sformatf("got delta %0d idx %0d updated %0b, want %0d %0d %0b",
                                    delta_ms_o, ref_index_o, updated_o,
                                    $signed(want.delta), want.idx, want.upd));
        end
      end
    end
  end

  // watchdog on cycles with no transaction, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : run_test
    int unsigned k, r, step, phase_len, span_val, near;
    stim_op_t    pause_op;
    for (k = 0; k < COS_ENTRIES; k++) cos_tab[k] = cos_q15(k);

    // directed: no reference, unused action, empty reference
    add_update(LAT_TOP, LON_BOTTOM, 32'hFFFF_FFFF);
    add_item(ACT_UNUSED, MAX_POINTS - 1, LAT_BOTTOM, LON_TOP, 32'hFFFF_FFFF);
    add_cfg(CFG_POINT_COUNT, 0);
    add_cfg(CFG_REF_VALID, 1);
    add_update(0, 0, 32'd5);
    // small lap with a duplicated point and points at the coordinate extremes
    add_item(ACT_LOAD, 0, 0, 0, 32'd1000);
    add_item(ACT_LOAD, 1, 1000, 1000, 32'd2000);
    add_item(ACT_LOAD, 2, 1000, 1000, 32'd3000);
    add_item(ACT_LOAD, 3, LAT_BOTTOM, LON_TOP, 32'hFFFF_FFFF);
    add_item(ACT_LOAD, MAX_POINTS - 1, LAT_TOP, LON_BOTTOM, 32'd0);
    add_cfg(CFG_POINT_COUNT, 4);
    // equal distances: lowest index wins, delta wraps negative
    add_update(1000, 1000, 32'd500);
    add_update(LAT_BOTTOM, LON_BOTTOM, 32'd0);
    add_update(LAT_BOTTOM, LON_TOP, 32'hFFFF_FFFF);
    // cursor past the point count: search starts at the last point
    add_cfg(CFG_POINT_COUNT, 2);
    add_update(0, 0, 32'd0);
    add_item(ACT_RESTART, 0, 0, 0, 32'd0);
    add_update(0, 0, 32'd7);
    // invalid reference reports held values
    add_cfg(CFG_REF_VALID, 0);
    add_update(5, 5, 32'd99);
    add_cfg(CFG_POINT_COUNT, 8191);
    add_update(LAT_TOP, LON_TOP, 32'h8000_0000);
    // hold off the random laps until every directed result is back
    pause_op      = '0;
    pause_op.kind = OP_DRAIN;
    pending_ops.push_back(pause_op);

    // random laps: mostly driving along the track, plus noise and stray transactions
    geo_lat0 = int'($urandom_range(0, 1600000000)) - 800000000;
    geo_lon0 = int'($urandom_range(0, 32'd3400000000) - 32'd1700000000);
    geo_dlat = jit(2000);
    geo_dlon = jit(2000);
    gen_pos  = 0;
    while (gen_items < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       span_val = 8191;
        1:       span_val = MAX_POINTS;
        2:       span_val = 1;
        3:       span_val = $urandom_range(100, 700);
        default: span_val = $urandom_range(2, 90);
      endcase
      add_cfg(CFG_POINT_COUNT, span_val);
      add_cfg(CFG_REF_VALID, $urandom_range(0, 6) != 0);
      phase_len = $urandom_range(25, 60);
      for (step = 0; step < phase_len && gen_items < ITEM_GOAL; step++) begin
        // hold off new transactions until every pending result is back
        if (step == phase_len / 2) begin
          pause_op      = '0;
          pause_op.kind = OP_DRAIN;
          pending_ops.push_back(pause_op);
        end
        r = $urandom_range(0, 99);
        if (r < 58) begin
          if (gen_span > 0 && gen_pos >= gen_span - 1 && $urandom_range(0, 1) == 1) begin
            // lap done, start over
            add_item(ACT_RESTART, $urandom_range(0, MAX_POINTS - 1), jit(1000), jit(1000),
                     $urandom);
          end else begin
            gen_pos += $urandom_range(0, 4);
            if (gen_span > 0 && gen_pos > gen_span - 1) gen_pos = gen_span - 1;
            if (gen_pos > MAX_POINTS - 1) gen_pos = MAX_POINTS - 1;
            add_update(geo_lat0 + int'(gen_pos) * geo_dlat + jit(400),
                       geo_lon0 + int'(gen_pos) * geo_dlon + jit(400),
                       gen_pos * 120 + jit(1500));
          end
        end else if (r < 70) begin
          add_update(int'($urandom), int'($urandom), $urandom);
        end else if (r < 82) begin
          add_item(ACT_LOAD, $urandom_range(0, MAX_POINTS - 1), int'($urandom), int'($urandom),
                   $urandom);
        end else if (r < 90) begin
          near = gen_pos + $urandom_range(0, 20);
          lap_point((near > MAX_POINTS - 1) ? MAX_POINTS - 1 : near);
        end else if (r < 95) begin
          add_item(ACT_RESTART, $urandom_range(0, MAX_POINTS - 1), int'($urandom),
                   int'($urandom), $urandom);
        end else begin
          add_item(ACT_UNUSED, $urandom_range(0, MAX_POINTS - 1), int'($urandom),
                   int'($urandom), $urandom);
        end
      end
    end

    // reset, then run until all transactions are taken and all results are back
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || start || delta_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (delta_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came", delta_expect_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
